// File: sv/stg_pkg.sv
`default_nettype none

package stg_pkg;

  localparam int K_W = 16;
  localparam int N_W = 17;
  localparam int C_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CORDIC_STEPS = 28;
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_SPIRAL = 2'd0,
    MODE_HALTON = 2'd1,
    MODE_ARCH   = 2'd2,
    MODE_DGM    = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 1'b0,
    REG_NUM  = 1'b1
  } cfg_reg_e;

  localparam logic signed [32:0] ONE_Q30 = 33'sh040000000;
  localparam logic [30:0] SPIRAL_C = 31'd1230417496;
  localparam logic [31:0] ARCH_LO = 32'h80B583EB;
  localparam logic [31:0] ARCH_HI = 32'h61C88646;
  localparam logic [47:0] DGM_G1 = 48'd131046651649665;
  localparam logic [47:0] DGM_G2 = 48'd192058202691525;
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
  // ceil(2^20/3): exact quotient by 3 for values below 2^19
  localparam logic [18:0] DIV3_RECIP = 19'd349526;

  typedef struct packed {
    logic               bad;
    logic signed [31:0] z;
    logic [31:0]        az;
  } job_t;

  // atan(2^-i) in turns, Q0.32
  function automatic logic [29:0] atan_turns(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/stg_if.sv
`default_nettype none

interface stg_in_if;
  logic                     valid;
  logic                     ready;
  logic [stg_pkg::K_W-1:0]  proj_index;
  modport source (output valid, output proj_index, input ready);
  modport sink   (input valid, input proj_index, output ready);
endinterface

interface stg_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [stg_pkg::C_W-1:0] coord_x;
  logic signed [stg_pkg::C_W-1:0] coord_y;
  logic signed [stg_pkg::C_W-1:0] coord_z;
  logic                           index_bad;
  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output index_bad, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input index_bad, output ready);
endinterface

interface stg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [stg_pkg::CFG_IDX_W-1:0] index;
  logic [stg_pkg::N_W-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/stg_div.sv
`default_nettype none

module stg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [33:0] den,
  output logic        done,
  output logic        busy,
  output logic [63:0] quot
);
  import stg_pkg::*;

  logic [63:0] nr;
  logic [33:0] rem;
  logic [33:0] den_r;
  logic [5:0]  cnt;
  logic [34:0] t;
  logic [34:0] diff;
  logic        ge;

  always_comb begin
    t    = {rem, nr[63]};
    diff = t - {1'b0, den_r};
    ge   = t >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nr    <= num;
        den_r <= den;
        rem   <= '0;
        quot  <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? diff[33:0] : t[33:0];
        quot <= {quot[62:0], ge};
        nr   <= {nr[62:0], 1'b0};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/stg_sqrt.sv
`default_nettype none

module stg_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic        busy,
  output logic [31:0] root
);
  import stg_pkg::*;

  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic [63:0] t;

  assign t    = res + bitv;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        v    <= val;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (v >= t) begin
          v   <= v - t;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/stg_front.sv
`default_nettype none

module stg_front #(
  parameter int MAX_PROJECTIONS = 65536
) (
  input  logic                    clk,
  input  logic                    rst,
  input  stg_pkg::mode_e          mode,
  input  logic [stg_pkg::N_W-1:0] num_projections,
  stg_in_if.sink                  din,
  output stg_pkg::job_t           job,
  output logic                    job_valid,
  input  logic                    job_ready
);
  import stg_pkg::*;

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_DIV  = 7'b0000010,
    F_SQRT = 7'b0000100,
    F_INC  = 7'b0001000,
    F_R3   = 7'b0010000,
    F_DGM  = 7'b0100000,
    F_PUSH = 7'b1000000
  } fstate_e;

  typedef enum logic [1:0] {
    D_SPZ = 2'd0,
    D_SPR = 2'd1,
    D_ARZ = 2'd2,
    D_R3  = 2'd3
  } dsel_e;

  fstate_e            state;
  dsel_e              dsel;
  logic [K_W-1:0]     k;
  logic [N_W-1:0]     n;
  logic               bad;
  logic signed [31:0] z;
  logic [31:0]        az;
  logic [31:0]        prev_azimuth;
  logic [31:0]        inc;
  logic [47:0]        p0;
  logic [47:0]        p1;
  logic [N_W-1:0]     ri;
  logic [17:0]        rd;
  logic [17:0]        rp;

  logic [N_W-1:0]     n_eff;
  logic               in_bad;
  logic [N_W-1:0]     arch_d;
  logic [33:0]        sp_den;
  logic [35:0]        q3p;
  logic [N_W-1:0]     q3;
  logic [1:0]         r3d;
  logic [31:0]        brv;

  logic        div_start;
  logic [63:0] div_num;
  logic [33:0] div_den;
  logic        div_done;
  logic        div_busy;
  logic [63:0] div_q;
  logic        sq_start;
  logic        sq_done;
  logic        sq_busy;
  logic [31:0] sq_root;

  function automatic logic [31:0] bitrev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  always_comb begin
    n_eff  = (int'(num_projections) > MAX_PROJECTIONS) ? N_W'(MAX_PROJECTIONS)
                                                      : num_projections;
    in_bad = N_W'(din.proj_index) >= n_eff;
    arch_d = (n_eff > N_W'(1)) ? n_eff - N_W'(1) : N_W'(1);
    sp_den = 34'(k) * 34'(n - N_W'(k));
    q3p    = 36'(ri) * 36'(DIV3_RECIP);
    q3     = N_W'(q3p >> 20);
    r3d    = 2'(ri - N_W'(q3 * N_W'(3)));
    brv    = bitrev32(32'(din.proj_index) + 32'd1);
  end

  // divider and root start pulses
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    if (state == F_IDLE && din.valid && !in_bad) begin
      if (mode == MODE_SPIRAL) begin
        div_start = 1'b1;
        div_num   = (64'(din.proj_index) << 31) + 64'(n_eff >> 1);
        div_den   = 34'(n_eff);
      end else if (mode == MODE_ARCH) begin
        div_start = 1'b1;
        div_num   = (64'(din.proj_index) << 31) + 64'(arch_d >> 1);
        div_den   = 34'(arch_d);
      end
    end
    if (state == F_DIV && div_done && dsel == D_SPZ && k != '0) begin
      div_start = 1'b1;
      div_num   = 64'(n) << 46;
      div_den   = sp_den;
    end
    if (state == F_R3 && ri == '0) begin
      div_start = 1'b1;
      div_num   = (64'(rd) << 32) + 64'(rp >> 1);
      div_den   = 34'(rp);
    end
    if (state == F_DIV && div_done && dsel == D_SPR) begin
      sq_start = 1'b1;
    end
  end

  stg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .busy  (div_busy),
    .quot  (div_q)
  );

  stg_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (div_q),
    .done  (sq_done),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  assign din.ready = (state == F_IDLE);
  assign job_valid = (state == F_PUSH);
  assign job.bad   = bad;
  assign job.z     = z;
  assign job.az    = az;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      dsel         <= D_SPZ;
      prev_azimuth <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (din.valid) begin
            k   <= din.proj_index;
            n   <= n_eff;
            bad <= in_bad;
            if (in_bad) begin
              z     <= '0;
              az    <= '0;
              state <= F_PUSH;
            end else begin
              case (mode)
                MODE_SPIRAL: begin
                  dsel  <= D_SPZ;
                  state <= F_DIV;
                end
                MODE_HALTON: begin
                  z     <= 32'($signed({2'b00, brv[31:1]}) - ONE_Q30);
                  ri    <= N_W'(din.proj_index) + N_W'(1);
                  rd    <= '0;
                  rp    <= 18'd1;
                  state <= F_R3;
                end
                MODE_ARCH: begin
                  p0    <= 48'(din.proj_index) * 48'(ARCH_LO);
                  dsel  <= D_ARZ;
                  state <= F_DIV;
                end
                default: begin
                  p0    <= 48'(din.proj_index) * DGM_G1;
                  p1    <= 48'(din.proj_index) * DGM_G2;
                  state <= F_DGM;
                end
              endcase
            end
          end
        end
        F_DIV: begin
          if (div_done) begin
            case (dsel)
              D_SPZ: begin
                z <= 32'($signed({1'b0, div_q[31:0]}) - ONE_Q30);
                if (k == '0) begin
                  az           <= '0;
                  prev_azimuth <= '0;
                  state        <= F_PUSH;
                end else begin
                  dsel <= D_SPR;
                end
              end
              D_SPR: begin
                state <= F_SQRT;
              end
              D_ARZ: begin
                z     <= 32'(ONE_Q30 - $signed({1'b0, div_q[31:0]}));
                az    <= 32'((64'(p0) + 64'h8000_0000) >> 32) +
                         32'(32'(k) * ARCH_HI);
                state <= F_PUSH;
              end
              default: begin
                az    <= div_q[31:0];
                state <= F_PUSH;
              end
            endcase
          end
        end
        F_SQRT: begin
          if (sq_done) begin
            inc   <= 32'((64'(SPIRAL_C) * 64'(sq_root) + 64'h40_0000) >> 23);
            state <= F_INC;
          end
        end
        F_INC: begin
          az           <= prev_azimuth + inc;
          prev_azimuth <= prev_azimuth + inc;
          state        <= F_PUSH;
        end
        F_R3: begin
          if (ri != '0) begin
            rd <= 18'(rd * 18'd3) + 18'(r3d);
            rp <= 18'(rp * 18'd3);
            ri <= q3;
          end else begin
            dsel  <= D_R3;
            state <= F_DIV;
          end
        end
        F_DGM: begin
          z     <= 32'($signed({2'b00, p0[47:17]}) - ONE_Q30);
          az    <= p1[47:16];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sqrt_free: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> !sq_busy)
    else $error("root unit started while busy");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.bad) |-> (job.z == '0 && job.az == '0))
    else $error("flagged transaction carries nonzero payload");
`endif

endmodule

`default_nettype wire

// File: sv/stg_fifo.sv
`default_nettype none

module stg_fifo (
  input  logic          clk,
  input  logic          rst,
  input  stg_pkg::job_t in_data,
  input  logic          in_valid,
  output logic          in_ready,
  output stg_pkg::job_t out_data,
  output logic          out_valid,
  input  logic          out_ready
);
  import stg_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  job_t          mem [Q_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;
  logic          push;
  logic          pop;

  assign in_ready  = cnt != CW'(Q_DEPTH);
  assign out_valid = cnt != '0;
  assign out_data  = mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + PW'(1);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + CW'(1);
        2'b01:   cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// File: sv/stg_back.sv
`default_nettype none

module stg_back #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic          clk,
  input  logic          rst,
  input  stg_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  stg_out_if.source     dout
);
  import stg_pkg::*;

  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam logic signed [39:0] RND = (40'sd1 <<< SH) >>> 1;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_SQ   = 6'b000010,
    B_SQW  = 6'b000100,
    B_GAIN = 6'b001000,
    B_ROT  = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_e;

  bstate_e            state;
  logic               bad;
  logic signed [31:0] z;
  logic [31:0]        az;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] a;
  logic [4:0]         step;
  logic               ovalid;
  logic [C_W-1:0]     ox;
  logic [C_W-1:0]     oy;
  logic [C_W-1:0]     oz;
  logic               obad;

  logic [31:0]        zabs;
  logic [30:0]        za;
  logic [63:0]        sq_val;
  logic               sq_start;
  logic               sq_done;
  logic               sq_busy;
  logic [31:0]        sq_root;
  logic [31:0]        uq;
  logic               flip;
  logic [31:0]        u2;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic               out_free;

  function automatic logic [C_W-1:0] to_field(input logic signed [39:0] v);
    logic signed [39:0] t;
    logic [C_W-1:0]     r;
    t = (v + RND) >>> SH;
    if (t > 40'sd32767) begin
      r = 16'h7FFF;
    end else if (t < -40'sd32768) begin
      r = 16'h8000;
    end else begin
      r = t[C_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    zabs     = z[31] ? 32'(-z) : 32'(z);
    za       = (zabs > 32'h4000_0000) ? 31'h4000_0000 : zabs[30:0];
    sq_val   = 64'h1000_0000_0000_0000 - (64'(za) * 64'(za));
    sq_start = (state == B_SQ);
    uq       = az + 32'h4000_0000;
    flip     = uq >= 32'h8000_0000;
    u2       = flip ? az - 32'h8000_0000 : az;
    xs       = x >>> step;
    ys       = y >>> step;
    at       = $signed({4'b0000, atan_turns(step)});
    out_free = !ovalid || dout.ready;
  end

  stg_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (sq_val),
    .done  (sq_done),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  assign job_ready      = (state == B_IDLE);
  assign dout.valid     = ovalid;
  assign dout.coord_x   = ox;
  assign dout.coord_y   = oy;
  assign dout.coord_z   = oz;
  assign dout.index_bad = obad;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      ovalid <= 1'b0;
    end else begin
      // B_OUT reloads the register itself when it is free
      if (ovalid && dout.ready && state != B_OUT) begin
        ovalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            bad   <= job.bad;
            z     <= job.z;
            az    <= job.az;
            state <= job.bad ? B_OUT : B_SQ;
          end
        end
        B_SQ: begin
          state <= B_SQW;
        end
        B_SQW: begin
          if (sq_done) begin
            x     <= 34'((64'(sq_root) * 64'(CORDIC_GAIN) + 64'h2000_0000) >> 30);
            state <= B_GAIN;
          end
        end
        B_GAIN: begin
          // fold left half-plane angles into the right one
          if (flip) begin
            x <= -x;
          end
          y     <= '0;
          a     <= 34'($signed(u2));
          step  <= '0;
          state <= B_ROT;
        end
        B_ROT: begin
          if (!a[33]) begin
            x <= x - ys;
            y <= y + xs;
            a <= a - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            a <= a + at;
          end
          step <= step + 5'd1;
          if (step == 5'(CORDIC_STEPS - 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            ovalid <= 1'b1;
            obad   <= bad;
            ox     <= bad ? '0 : to_field(40'(x));
            oy     <= bad ? '0 : to_field(40'(y));
            oz     <= bad ? '0 : to_field(40'(z));
            state  <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_bad_out_zero: assert property (@(posedge clk) disable iff (rst)
    (ovalid && obad) |-> (ox == '0 && oy == '0 && oz == '0))
    else $error("flagged result with nonzero coordinates");

  a_sqrt_free: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> !sq_busy)
    else $error("root unit started while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !dout.ready) |=> ovalid)
    else $error("pending result dropped");
`endif

endmodule

`default_nettype wire

// File: sv/sphere_trajectory_point_gen.sv
// Unit-sphere trajectory point generator.
// din carries a projection index; dout returns one direction per index as
// signed x, y, z (OUT_FRAC_BITS fraction bits) plus index_bad, set with zero
// coordinates when the index is not below num_projections. cfg writes the
// mode (index 0) and num_projections (index 1); write it only when idle.
// Spiral mode keeps the last azimuth, so its indices should arrive in order.
// A front end takes each index and makes z and the azimuth; a two-entry
// queue passes the job to a back end that forms sqrt(1 - z^2) and rotates it
// through 28 CORDIC steps into a result register.
// Front work per index: spiral makes two restoring divisions on the shared
// divider (one for index 0) plus a square root, halton a base-3 digit loop
// plus one division, archimedean one division, golden means no division.
// Back end: a square root plus the 28 CORDIC steps. The front end takes a new
// index only once its job is queued; the slower half sets the sustained rate.
// Reset returns mode to spiral, num_projections to 1024 and clears the stored
// azimuth. When dout stalls, the result register holds and the back end
// waits, the queue fills, and then din.ready stays low.
`default_nettype none

module sphere_trajectory_point_gen #(
  parameter int MAX_PROJECTIONS = 65536,
  parameter int OUT_FRAC_BITS   = 15
) (
  input  logic       clk,
  input  logic       rst,
  stg_cfg_if.sink    cfg,
  stg_in_if.sink     din,
  stg_out_if.source  dout
);
  import stg_pkg::*;

  mode_e          mode;
  logic [N_W-1:0] num_projections;

  job_t f_job;
  logic f_valid;
  logic f_ready;
  job_t b_job;
  logic b_valid;
  logic b_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_SPIRAL;
      num_projections <= N_W'(1024);
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.index))
        REG_MODE: mode            <= mode_e'(cfg.data[1:0]);
        REG_NUM:  num_projections <= cfg.data;
        default:  ;
      endcase
    end
  end

  stg_front #(
    .MAX_PROJECTIONS (MAX_PROJECTIONS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .mode            (mode),
    .num_projections (num_projections),
    .din             (din),
    .job             (f_job),
    .job_valid       (f_valid),
    .job_ready       (f_ready)
  );

  stg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_data   (f_job),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_data  (b_job),
    .out_valid (b_valid),
    .out_ready (b_ready)
  );

  stg_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (b_job),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .dout      (dout)
  );

endmodule

`default_nettype wire

// File: test/sphere_trajectory_point_gen_test.sv
`default_nettype none

module sphere_trajectory_point_gen_test;
  import stg_pkg::*;

  localparam longint unsigned ONE_Z      = 64'd1 << 30;
  localparam longint unsigned SPIRAL_K   = 64'd1230417496;
  localparam longint unsigned GOLDEN_INC = 64'h61C8864680B583EB;
  localparam longint unsigned GM_G1      = 64'd131046651649665;
  localparam longint unsigned GM_G2      = 64'd192058202691525;
  localparam longint unsigned MASK48     = (64'd1 << 48) - 64'd1;
  localparam longint unsigned ROT_GAIN   = 64'd652032874;
  localparam int              LIMIT      = 1500000;
  localparam int              SETTLE     = 400;

  localparam longint ATAN_TURN [28] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               bad;
  } point_t;

  typedef struct {
    mode_e       mode;
    logic [16:0] num;
    logic [15:0] k;
    bit          lit;
    point_t      pt;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stg_cfg_if cfg_bus();
  stg_in_if  in_bus();
  stg_out_if out_bus();

  sphere_trajectory_point_gen i_dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_bus.sink),
    .din  (in_bus.sink),
    .dout (out_bus.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mode_e       cur_mode   = MODE_SPIRAL;
  logic [16:0] cur_num    = 17'd1024;
  logic [31:0] spiral_az  = '0;
  point_t      pending_pts[$];
  int          errors     = 0;
  int          cycles     = 0;
  int          src_idle   = 0;
  int          snk_idle   = 0;
  int          sent       = 0;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] to_q15(longint v);
    longint s;
    s = (v + 64'sd16384) >>> 15;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  // Expected point for index k; advances the stored spiral azimuth.
  function automatic point_t sphere_point(logic [15:0] k16);
    longint unsigned k, n, d, den, s, inc, za, r, dd, pp;
    longint z, x, y, a, nx, ny;
    logic [31:0] az, u, rev, kk;
    point_t pt;
    k = k16;
    n = cur_num;
    if (n > 65536) n = 65536;
    pt = '0;
    if (k >= n) begin
      pt.bad = 1'b1;
      return pt;
    end
    case (cur_mode)
      MODE_SPIRAL: begin
        z = longint'(((k << 31) + n / 2) / n) - longint'(ONE_Z);
        if (k == 0) begin
          az = '0;
        end else begin
          den = k * (n - k);
          s = floor_sqrt((n << 46) / den);
          inc = (SPIRAL_K * s + (64'd1 << 22)) >> 23;
          az = spiral_az + inc[31:0];
        end
        spiral_az = az;
      end
      MODE_HALTON: begin
        kk = k + 1;
        for (int i = 0; i < 32; i++) rev[i] = kk[31-i];
        z = longint'({32'd0, rev} >> 1) - longint'(ONE_Z);
        dd = 0;
        pp = 1;
        while (kk > 0) begin
          dd = dd * 3 + kk % 3;
          pp = pp * 3;
          kk = kk / 3;
        end
        az = (((dd << 32) + pp / 2) / pp);
      end
      MODE_ARCH: begin
        d = (n > 1) ? n - 1 : 1;
        z = longint'(ONE_Z) - longint'(((k << 31) + d / 2) / d);
        inc = (k * GOLDEN_INC + (64'd1 << 31)) >> 32;
        az = inc[31:0];
      end
      default: begin
        inc = ((k * GM_G1) & MASK48) >> 16;
        z = longint'({32'd0, inc[31:0]} >> 1) - longint'(ONE_Z);
        inc = ((k * GM_G2) & MASK48) >> 16;
        az = inc[31:0];
      end
    endcase
    za = (z < 0) ? longint'(-z) : longint'(z);
    if (za > ONE_Z) za = ONE_Z;
    r = floor_sqrt((64'd1 << 60) - za * za);
    x = longint'((r * ROT_GAIN + (64'd1 << 29)) >> 30);
    y = 0;
    u = az;
    if (u + 32'h40000000 >= 32'h80000000) begin
      u = u - 32'h80000000;
      x = -x;
    end
    a = longint'($signed(u));
    for (int i = 0; i < 28; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        a = a - ATAN_TURN[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        a = a + ATAN_TURN[i];
      end
      x = nx;
      y = ny;
    end
    pt.x = to_q15(x);
    pt.y = to_q15(y);
    pt.z = to_q15(z);
    return pt;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic drain();
    wait (pending_pts.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // valid is left high; the caller drops it after the last write
  task automatic write_reg(cfg_reg_e idx, logic [16:0] val);
    bit took;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do begin
      @(negedge clk);
      took = cfg_bus.ready;
      @(posedge clk);
    end while (!took);
    if (idx == REG_MODE) cur_mode = mode_e'(val[1:0]);
    else cur_num = val;
  endtask

  task automatic set_config(mode_e m, logic [16:0] n);
    in_bus.valid <= 1'b0;
    drain();
    write_reg(REG_MODE, {15'd0, m});
    write_reg(REG_NUM, n);
    cfg_bus.valid <= 1'b0;
  endtask

  // One index transaction; valid stays up into the next call unless it idles.
  task automatic send_index(logic [15:0] k, bit lit, point_t lit_pt);
    bit took;
    point_t pt;
    while ($urandom_range(99) < src_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.proj_index <= k;
    do begin
      @(negedge clk);
      took = in_bus.ready;
      @(posedge clk);
    end while (!took);
    pt = sphere_point(k);
    pending_pts.push_back(lit ? lit_pt : pt);
    sent++;
  endtask

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= snk_idle);
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("sphere_trajectory_point_gen regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    point_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (pending_pts.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        want = pending_pts.pop_front();
        if (out_bus.index_bad !== want.bad) report("index_bad", out_bus.index_bad, want.bad);
        if (out_bus.coord_x !== want.x) report("coord_x", out_bus.coord_x, want.x);
        if (out_bus.coord_y !== want.y) report("coord_y", out_bus.coord_y, want.y);
        if (out_bus.coord_z !== want.z) report("coord_z", out_bus.coord_z, want.z);
      end
    end
  end

  initial begin
    row_t   rows[$];
    point_t zero_pt, bad_pt, south, north;
    mode_e  m;
    int     n, len, start, total;

    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_MODE;
    cfg_bus.data      = '0;
    in_bus.valid      = 1'b0;
    in_bus.proj_index = '0;
    out_bus.ready     = 1'b0;
    zero_pt = '0;
    bad_pt  = '0;
    bad_pt.bad = 1'b1;
    south = '0;
    south.z = -16'sd32768;
    north = '0;
    north.z = 16'sd32767;

    // poles and bad indexes are known outright; the rest goes to the predictor
    rows = '{
      '{MODE_SPIRAL, 17'd1024,   16'd0,     1, south},
      '{MODE_SPIRAL, 17'd1024,   16'd1,     0, zero_pt},
      '{MODE_SPIRAL, 17'd1024,   16'd2,     0, zero_pt},
      '{MODE_SPIRAL, 17'd1024,   16'd3,     0, zero_pt},
      '{MODE_SPIRAL, 17'd1024,   16'd1023,  0, zero_pt},
      '{MODE_SPIRAL, 17'd1024,   16'd1024,  1, bad_pt},
      '{MODE_SPIRAL, 17'd1024,   16'd65535, 1, bad_pt},
      '{MODE_HALTON, 17'd65536,  16'd0,     0, zero_pt},
      '{MODE_HALTON, 17'd65536,  16'd1,     0, zero_pt},
      '{MODE_HALTON, 17'd65536,  16'd2,     0, zero_pt},
      '{MODE_HALTON, 17'd65536,  16'd65535, 0, zero_pt},
      '{MODE_ARCH,   17'd65536,  16'd0,     1, north},
      '{MODE_ARCH,   17'd65536,  16'd32768, 0, zero_pt},
      '{MODE_ARCH,   17'd65536,  16'd65535, 0, zero_pt},
      '{MODE_DGM,    17'd65536,  16'd0,     1, south},
      '{MODE_DGM,    17'd65536,  16'd12345, 0, zero_pt},
      '{MODE_DGM,    17'd65536,  16'd65535, 0, zero_pt},
      '{MODE_ARCH,   17'd1,      16'd0,     1, north},
      '{MODE_ARCH,   17'd1,      16'd1,     1, bad_pt},
      '{MODE_SPIRAL, 17'd0,      16'd0,     1, bad_pt},
      '{MODE_DGM,    17'd2,      16'd1,     0, zero_pt},
      '{MODE_DGM,    17'd2,      16'd2,     1, bad_pt},
      '{MODE_SPIRAL, 17'd131071, 16'd0,     1, south},
      '{MODE_SPIRAL, 17'd131071, 16'd1,     0, zero_pt},
      '{MODE_SPIRAL, 17'd131071, 16'd65535, 0, zero_pt}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].mode != cur_mode || rows[i].num != cur_num)
        set_config(rows[i].mode, rows[i].num);
      send_index(rows[i].k, rows[i].lit, rows[i].pt);
    end

    total = sent + 625;
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 7 : (ph == 1) ? 57 : 0;
      snk_idle = (ph == 0) ? 57 : (ph == 1) ? 7 : 0;
      while (sent < total - (2 - ph) * 208) begin
        m = mode_e'($urandom_range(3));
        case ($urandom_range(9))
          0:       n = 65536;
          1:       n = $urandom_range(131071);
          2:       n = 2;
          default: n = $urandom_range(2, 300);
        endcase
        set_config(m, n[16:0]);
        len = $urandom_range(4, 30);
        start = 0;
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(9) == 0 || (m != MODE_SPIRAL && $urandom_range(1) == 0))
            send_index($urandom_range(65535), 0, zero_pt);
          else if (m == MODE_SPIRAL || $urandom_range(1) == 0)
            send_index((n > 0) ? (start + j) % n : j, 0, zero_pt);
          else
            send_index($urandom_range((n > 1) ? n : 1), 0, zero_pt);
        end
      end
    end
    in_bus.valid <= 1'b0;
    drain();
    if (errors == 0 && pending_pts.size() == 0) begin
      $display("sphere_trajectory_point_gen regression: pass");
    end else begin
      $display("sphere_trajectory_point_gen regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
sv/stg_pkg.sv
sv/stg_if.sv
sv/stg_div.sv
sv/stg_sqrt.sv
sv/stg_front.sv
sv/stg_fifo.sv
sv/stg_back.sv
sv/sphere_trajectory_point_gen.sv
test/sphere_trajectory_point_gen_test.sv
